FILE: rtl/dmx_rgbw_dimmer_with_strobe_defines.svh
// ----------------------------------------------------------------------------
// DMX RGBW dimmer assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef DMX_RGBW_DIMMER_WITH_STROBE_DEFINES_SVH
`define DMX_RGBW_DIMMER_WITH_STROBE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMXD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmxd assertion failed");
// next-cycle implication
`define DMXD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmxd assertion failed");
`else
`define DMXD_ASSERT_NOW(label, ante, cons)
`define DMXD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/dmxd_pkg.sv
// ----------------------------------------------------------------------------
// dmxd_pkg
// Types, strobe period table and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dmxd_pkg;

  localparam int unsigned PERIOD_W  = 13;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CH_COUNT  = 4;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 13'd8191;

  // fixture channel offsets from channel_base
  localparam logic [8:0] OFS_RED    = 9'd0;
  localparam logic [8:0] OFS_GREEN  = 9'd1;
  localparam logic [8:0] OFS_BLUE   = 9'd2;
  localparam logic [8:0] OFS_WHITE  = 9'd3;
  localparam logic [8:0] OFS_DIMMER = 9'd4;
  localparam logic [8:0] OFS_STROBE = 9'd5;

  localparam logic [7:0] STROBE_DARK_BELOW  = 8'd10;
  localparam logic [7:0] STROBE_STEADY_OVER = 8'd245;

  localparam logic [63:0] Q_ONE = 64'h0001_0000_0000_0000;

  typedef logic [255:0][PERIOD_W-1:0] period_tab_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SCALE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       div_step;
    logic       scale_step;
    logic [1:0] scale_sel;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

  // floor(a*b / 2^48)
  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[111:48];
  endfunction

  function automatic logic [63:0] q_pow235(logic [63:0] r);
    logic [63:0] acc;
    acc = Q_ONE;
    for (int i = 0; i < 235; i++) begin
      acc = q_mul(acc, r);
    end
    return acc;
  endfunction

  // shift-subtract quotient, elaboration use only
  function automatic logic [63:0] q_udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // period[s] = floor(10000*2^48 / (249*X - 247*2^48)), X = r^(s-10)
  function automatic period_tab_t build_periods();
    period_tab_t tab;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] x;
    logic [63:0] d;
    logic [63:0] p;
    lo = Q_ONE;
    hi = Q_ONE + (Q_ONE >> 7);
    while (hi - lo > 64'd1) begin
      mid = lo + ((hi - lo) >> 1);
      if (q_pow235(mid) <= (Q_ONE << 1)) lo = mid;
      else hi = mid;
    end
    x = Q_ONE;
    for (int s = 0; s < 256; s++) begin
      if (s < 10) begin
        tab[s] = PERIOD_MAX;
      end else begin
        if (s > 10) x = q_mul(x, lo);
        d = 64'd249 * x - 64'd247 * Q_ONE;
        p = (d == 64'd0) ? 64'(PERIOD_MAX) : q_udiv(64'd10000 << 48, d);
        tab[s] = (p > 64'(PERIOD_MAX)) ? PERIOD_MAX : p[PERIOD_W-1:0];
      end
    end
    return tab;
  endfunction

  localparam period_tab_t PERIOD_TABLE = build_periods();

endpackage

FILE: rtl/dmxd_ctrl.sv
// ----------------------------------------------------------------------------
// dmxd_ctrl
// Sequencer: accept, 32 divide steps, 4 scale steps, output hand-off.
// ----------------------------------------------------------------------------
`include "dmx_rgbw_dimmer_with_strobe_defines.svh"

module dmxd_ctrl
  import dmxd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [4:0] cnt;
  logic [4:0] cnt_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.scale_sel  = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'd31) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        cnt_next       = cnt + 5'd1;
        if (cnt[1:0] == 2'd3) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `DMXD_ASSERT_NOW(a_load_needs_room, cmd.out_load, status.out_free)
  `DMXD_ASSERT_NEXT(a_accept_starts_div, cmd.accept, state == S_DIV && cnt == 5'd0)
  `DMXD_ASSERT_NEXT(a_div_ends_in_scale, state == S_DIV && cnt == 5'd31,
                    state == S_SCALE && cnt[1:0] == 2'd0)

endmodule

FILE: rtl/dmxd_datapath.sv
// ----------------------------------------------------------------------------
// dmxd_datapath
// Channel registers, ms counter, serial divider, shared scaler, output reg.
// ----------------------------------------------------------------------------
module dmxd_datapath
  import dmxd_pkg::*;
#(
  parameter int SLOT_COUNT = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  input  logic         channel_base_we,
  input  logic [8:0]   channel_base,
  input  logic         req_type,
  input  logic [8:0]   slot_index,
  input  logic [7:0]   slot_value,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [39:0]  out_data
);

  logic [8:0]          base;
  logic [7:0]          red_value;
  logic [7:0]          green_value;
  logic [7:0]          blue_value;
  logic [7:0]          white_value;
  logic [7:0]          dimmer_value;
  logic [7:0]          strobe_value;
  logic [PERIOD_W-1:0] strobe_period_ms;
  logic [MS_W-1:0]     ms_count;
  logic [MS_W-1:0]     ms_count_next;

  logic [MS_W-1:0]     div_shift;
  logic [PERIOD_W-1:0] div_rem;
  logic [PERIOD_W:0]   div_trial;
  logic                div_qbit;

  logic [8:0]          slot_ofs;
  logic                slot_hit;
  logic                phase;
  logic [7:0]          colour;
  logic [15:0]         prod;
  logic [16:0]         prod_adj;
  logic [CH_COUNT-1:0][LEVEL_W-1:0] levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (channel_base_we) begin
      base <= channel_base;
    end
  end

  // slot decode; slots at or past SLOT_COUNT never land
  assign slot_ofs = slot_index - base;
  assign slot_hit = ({1'b0, slot_index} < 10'(SLOT_COUNT)) && (slot_index >= base)
                    && (slot_ofs <= OFS_STROBE);
  assign ms_count_next = req_type ? ms_count + 32'd1 : ms_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_value        <= '0;
      green_value      <= '0;
      blue_value       <= '0;
      white_value      <= '0;
      dimmer_value     <= '0;
      strobe_value     <= '0;
      strobe_period_ms <= '0;
      ms_count         <= '0;
    end else if (cmd.accept) begin
      ms_count <= ms_count_next;
      if (!req_type && slot_hit) begin
        unique case (slot_ofs)
          OFS_RED:    red_value    <= slot_value;
          OFS_GREEN:  green_value  <= slot_value;
          OFS_BLUE:   blue_value   <= slot_value;
          OFS_WHITE:  white_value  <= slot_value;
          OFS_DIMMER: dimmer_value <= slot_value;
          default: begin
            strobe_value     <= slot_value;
            strobe_period_ms <= PERIOD_TABLE[slot_value];
          end
        endcase
      end
    end
  end

  // restoring divider, one quotient bit per step; only the last bit is kept
  assign div_trial = {div_rem, div_shift[MS_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_shift <= ms_count_next;
      div_rem   <= '0;
      div_qbit  <= 1'b0;
    end else if (cmd.div_step) begin
      div_shift <= {div_shift[MS_W-2:0], 1'b0};
      if (div_trial >= {1'b0, strobe_period_ms}) begin
        div_rem  <= PERIOD_W'(div_trial - {1'b0, strobe_period_ms});
        div_qbit <= 1'b1;
      end else begin
        div_rem  <= div_trial[PERIOD_W-1:0];
        div_qbit <= 1'b0;
      end
    end
  end

  always_comb begin
    if (strobe_value < STROBE_DARK_BELOW) begin
      phase = 1'b0;
    end else if (strobe_value > STROBE_STEADY_OVER) begin
      phase = 1'b1;
    end else if (strobe_period_ms == '0) begin
      phase = 1'b0;
    end else begin
      phase = div_qbit;
    end
  end

  // one shared multiplier; p/255 = (p + (p>>8) + 1) >> 8 for p <= 255*255
  always_comb begin
    unique case (cmd.scale_sel)
      2'd0: colour = red_value;
      2'd1: colour = green_value;
      2'd2: colour = blue_value;
      2'd3: colour = white_value;
      default: colour = red_value;
    endcase
  end

  assign prod     = colour * dimmer_value;
  assign prod_adj = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.scale_step) begin
      levels[cmd.scale_sel] <= phase ? prod_adj[15:8] : 8'd0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {7'd0, phase, levels[3], levels[2], levels[1], levels[0]};
    end
  end

endmodule

FILE: rtl/dmx_rgbw_dimmer_with_strobe.sv
// Flow: input transfer, divide steps, scale steps, then the load into the output register once it is free.
// One item in flight at a time: s_tready is high only while the controller is idle.
// The result sits in an output register, so a new item is taken while it waits.
// Reset (rst, synchronous): channel values, period, ms counter and base go to zero.
// ----------------------------------------------------------------------------
// dmx_rgbw_dimmer_with_strobe
// RGBW fixture: latches six DMX slots, counts ms ticks, and emits dimmed,
// strobe-gated levels for every input item.
// ----------------------------------------------------------------------------
module dmx_rgbw_dimmer_with_strobe
  import dmxd_pkg::*;
#(
  parameter int SLOT_COUNT = 512   // slots at or above this are ignored
) (
  input  logic        clk,
  input  logic        rst,
  // channel_base register write
  input  logic        channel_base_we,
  input  logic [8:0]  channel_base,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [8:0] slot_index, [16:9] slot_value, rest zero
  input  logic        s_tuser,   // [0] req_type: 0 slot write, 1 ms tick
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue,
                                 // [31:24] white, [32] strobe_phase, rest zero
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Controller: idle -> 32 divide steps (ms_count / period, LSB of quotient
  // gives the flash phase) -> 4 scale steps through one 8x8 multiplier ->
  // hand-off into the output register once it is free.
  dmxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the input transfer updates the channel registers or the ms
  // counter and seeds the divider with the post-update count.
  dmxd_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .channel_base_we (channel_base_we),
    .channel_base    (channel_base),
    .req_type        (s_tuser),
    .slot_index      (s_tdata[8:0]),
    .slot_value      (s_tdata[16:9]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_data        (m_tdata)
  );

endmodule
